// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the ranking block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, ignored while reset is high
`define PFR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that holds at every edge, reset included
`define PFR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/pfr_pkg.sv =====
package pfr_pkg;

   // Defaults for the top-level parameters
   localparam int MaxPointsDef = 64;
   localparam int ObjWidthDef  = 32;

   // Fixed result field widths
   localparam int PIDX_W = 6;
   localparam int RANK_W = 7;

   // Input word: one point
   typedef struct packed {
      logic signed [31:0] objective_a;
      logic signed [31:0] objective_b;
      logic               last_point;
   } req_word_type;

   // Result word: one ranked point
   typedef struct packed {
      logic [PIDX_W-1:0] point_index;
      logic [RANK_W-1:0] front_rank;
      logic              overflow;
      logic              last_result;
   } rsp_word_type;

   // Control of the objective store
   typedef struct packed {
      logic wr_en;
      logic ref_load;
   } obj_ctl_type;

   // Control of the dominator row store
   typedef struct packed {
      logic wr_en;
   } row_ctl_type;

endpackage

// ===== hdl/pfr_obj_mem.sv =====
module pfr_obj_mem #(
   parameter int MAX_POINTS      = pfr_pkg::MaxPointsDef,
   parameter int OBJECTIVE_WIDTH = pfr_pkg::ObjWidthDef
) (
   input  logic                           clock,
   input  pfr_pkg::obj_ctl_type           ctl,
   input  logic [$clog2(MAX_POINTS)-1:0]  wr_addr,
   input  logic [OBJECTIVE_WIDTH-1:0]     wr_a,
   input  logic [OBJECTIVE_WIDTH-1:0]     wr_b,
   input  logic [$clog2(MAX_POINTS)-1:0]  rd_addr,
   output logic                           dominates
);
   import pfr_pkg::*;

   localparam int PW = 2 * OBJECTIVE_WIDTH;

   logic [PW-1:0] mem [MAX_POINTS];
   logic [PW-1:0] rd_data_ff;
   logic [PW-1:0] ref_ff;
   logic signed [OBJECTIVE_WIDTH-1:0] pa, pb, qa, qb;

   // Objective store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= {wr_b, wr_a};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Reference point held for a whole comparison sweep
   always_ff @(posedge clock) begin
      if (ctl.ref_load) begin
         ref_ff <= rd_data_ff;
      end
   end

   // Strict dominance: point just read against the reference point
   always_comb begin
      pa = $signed(rd_data_ff[OBJECTIVE_WIDTH-1:0]);
      pb = $signed(rd_data_ff[PW-1:OBJECTIVE_WIDTH]);
      qa = $signed(ref_ff[OBJECTIVE_WIDTH-1:0]);
      qb = $signed(ref_ff[PW-1:OBJECTIVE_WIDTH]);
      dominates = (pa <= qa) && (pb <= qb) && ((pa < qa) || (pb < qb));
   end

endmodule

// ===== hdl/pfr_row_mem.sv =====
module pfr_row_mem #(
   parameter int MAX_POINTS = pfr_pkg::MaxPointsDef
) (
   input  logic                           clock,
   input  pfr_pkg::row_ctl_type           ctl,
   input  logic [$clog2(MAX_POINTS)-1:0]  wr_addr,
   input  logic [MAX_POINTS-1:0]          wr_row,
   input  logic [$clog2(MAX_POINTS)-1:0]  rd_addr,
   input  logic [MAX_POINTS-1:0]          done_mask,
   output logic                           released
);
   import pfr_pkg::*;

   // Row j: bit i set when point i dominates point j
   logic [MAX_POINTS-1:0] mem [MAX_POINTS];
   logic [MAX_POINTS-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= mem[rd_addr];
   end

   // Released once every dominator sits in an earlier front
   assign released = ((rd_row_ff & ~done_mask) == '0);

endmodule

// ===== hdl/pareto_front_ranking.sv =====
// Pareto front ranking for two minimised objectives. Points are loaded one
// word per cycle; the word flagged last_point starts ranking and req_stall
// stays high until the last result word is loaded into the output register.
// Ranking runs a dominance sweep per stored point (one stored point read
// per cycle from the objective memory), then one peeling pass over the
// dominator row memory per front; rsp_stall can hold up a peeling pass.
// Points beyond MAX_POINTS are dropped and every result of that run carries
// overflow.
`include "assert_macros.svh"

module pareto_front_ranking #(
   parameter int MAX_POINTS      = pfr_pkg::MaxPointsDef,
   parameter int OBJECTIVE_WIDTH = pfr_pkg::ObjWidthDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pfr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pfr_pkg::rsp_word_type rsp_word
);
   import pfr_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RDJ   = 7'b0000010,
      S_CAPJ  = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_WR    = 7'b0010000,
      S_PRD   = 7'b0100000,
      S_PEV   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [CNT_W-1:0]      i_ff, i_in;
   logic                  dv_ff, dv_in;
   logic [IDX_W-1:0]      di_ff, di_in;
   logic [MAX_POINTS-1:0] acc_ff, acc_in;
   logic [MAX_POINTS-1:0] done_ff, done_in;
   logic [MAX_POINTS-1:0] new_ff, new_in;
   logic [CNT_W-1:0]      rank_ff, rank_in;
   logic [CNT_W-1:0]      emit_ff, emit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   obj_ctl_type           obj_ctl;
   row_ctl_type           row_ctl;
   logic [IDX_W-1:0]      obj_rd_addr;
   logic                  dominates;
   logic                  released;
   logic                  accept;
   logic                  slot_free;
   logic                  member;
   logic                  issue;
   logic [MAX_POINTS-1:0] bit_j;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == S_SCAN) && (i_ff < count_ff);
   assign member    = released && !done_ff[j_ff[IDX_W-1:0]];
   assign bit_j     = MAX_POINTS'(1) << j_ff[IDX_W-1:0];

   // Store control
   always_comb begin
      obj_ctl.wr_en    = accept && (count_ff < CNT_W'(MAX_POINTS));
      obj_ctl.ref_load = (state_ff == S_CAPJ);
      row_ctl.wr_en    = (state_ff == S_WR);
      obj_rd_addr      = (state_ff == S_SCAN) ? i_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];
   end

   pfr_obj_mem #(
      .MAX_POINTS      (MAX_POINTS),
      .OBJECTIVE_WIDTH (OBJECTIVE_WIDTH)
   ) u_obj (
      .clock     (clock),
      .ctl       (obj_ctl),
      .wr_addr   (count_ff[IDX_W-1:0]),
      .wr_a      (req_word.objective_a[OBJECTIVE_WIDTH-1:0]),
      .wr_b      (req_word.objective_b[OBJECTIVE_WIDTH-1:0]),
      .rd_addr   (obj_rd_addr),
      .dominates (dominates)
   );

   pfr_row_mem #(
      .MAX_POINTS (MAX_POINTS)
   ) u_row (
      .clock     (clock),
      .ctl       (row_ctl),
      .wr_addr   (j_ff[IDX_W-1:0]),
      .wr_row    (acc_ff),
      .rd_addr   (j_ff[IDX_W-1:0]),
      .done_mask (done_ff),
      .released  (released)
   );

   // Sequencer: load, dominance sweep, front peeling
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      dv_in        = issue;
      di_in        = i_ff[IDX_W-1:0];
      acc_in       = acc_ff;
      done_in      = done_ff;
      new_in       = new_ff;
      rank_in      = rank_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      if (issue) begin
         i_in = i_ff + CNT_W'(1);
      end
      if (dv_ff && dominates) begin
         acc_in[di_ff] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (obj_ctl.wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_word.last_point) begin
                  j_in     = '0;
                  state_in = S_RDJ;
               end
            end
         end
         S_RDJ: begin
            state_in = S_CAPJ;
         end
         S_CAPJ: begin
            i_in     = '0;
            acc_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (dv_ff && (CNT_W'(di_ff) == count_ff - CNT_W'(1))) begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            if (j_ff + CNT_W'(1) == count_ff) begin
               j_in     = '0;
               done_in  = '0;
               new_in   = '0;
               rank_in  = CNT_W'(1);
               emit_in  = '0;
               state_in = S_PRD;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = S_RDJ;
            end
         end
         S_PRD: begin
            state_in = S_PEV;
         end
         S_PEV: begin
            if (!member || slot_free) begin
               if (member) begin
                  rsp_valid_in            = 1'b1;
                  rsp_word_in.point_index = PIDX_W'(j_ff[IDX_W-1:0]);
                  rsp_word_in.front_rank  = RANK_W'(rank_ff);
                  rsp_word_in.overflow    = dropped_ff;
                  rsp_word_in.last_result = (emit_ff + CNT_W'(1) == count_ff);
                  new_in                  = new_ff | bit_j;
                  emit_in                 = emit_ff + CNT_W'(1);
               end
               // Last word loaded: the run is over
               if (emit_in == count_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_IDLE;
               end else if (j_ff + CNT_W'(1) == count_ff) begin
                  // End of a pass closes the front
                  done_in  = done_ff | new_in;
                  new_in   = '0;
                  rank_in  = rank_ff + CNT_W'(1);
                  j_in     = '0;
                  state_in = S_PRD;
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = S_PRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      i_ff        <= i_in;
      di_ff       <= di_in;
      acc_ff      <= acc_in;
      done_ff     <= done_in;
      new_ff      <= new_in;
      rank_ff     <= rank_in;
      emit_ff     <= emit_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `PFR_ASSERT(a_emit_bound, (state_ff == S_PEV) |-> (emit_ff < count_ff), "emitted all points yet still peeling")
   `PFR_ASSERT(a_rank_bound, (state_ff == S_PEV) |-> (rank_ff <= count_ff), "front number beyond point count")
   `PFR_ASSERT(a_last_once, (rsp_valid_in && !(rsp_valid_ff && rsp_stall) && rsp_word_in.last_result) |=> (state_ff == S_IDLE), "last word loaded but ranking continues")
   `PFR_ASSERT_ALWAYS(a_count_cap, (!reset) |-> (count_ff <= CNT_W'(MAX_POINTS)), "point count beyond capacity")

endmodule
